// ===== rtl/assert_macros.svh =====
// Shared assertion macros, clocked on clock and idle during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every edge.
`define MFBA_ALWAYS(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a consequent holds whenever an antecedent holds.
`define MFBA_IMPLY(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/mfba_pkg.sv =====
package mfba_pkg;

   localparam int CAP_W  = 30;
   localparam int FLOW_W = 32;
   localparam int TOT_W  = 38;
   localparam int NODE_W = 6;
   localparam int CNT_W  = 7;

   localparam logic [CAP_W-1:0] CAP_LIMIT    = 30'd1061109566;
   localparam logic [CAP_W-1:0] START_BOTTLE = 30'h3f3f3f3f;

   localparam logic [1:0] OP_ADD     = 2'd0;
   localparam logic [1:0] OP_COMPUTE = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;

   localparam logic [1:0] REG_SOURCE = 2'd0;
   localparam logic [1:0] REG_SINK   = 2'd1;
   localparam logic [1:0] REG_COUNT  = 2'd2;

   typedef struct packed {
      logic [NODE_W-1:0] source_node;
      logic [NODE_W-1:0] sink_node;
      logic [CNT_W-1:0]  node_count;
   } csr_type;

endpackage

// ===== rtl/mfba_csr.sv =====
module mfba_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output mfba_pkg::csr_type   cfg
);

   mfba_pkg::csr_type cfg_ff;
   mfba_pkg::csr_type cfg_in;
   logic              wr_en;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[3:2])
            mfba_pkg::REG_SOURCE: cfg_in.source_node = csr_pwdata[5:0];
            mfba_pkg::REG_SINK:   cfg_in.sink_node   = csr_pwdata[5:0];
            mfba_pkg::REG_COUNT:  cfg_in.node_count  = csr_pwdata[6:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         mfba_pkg::REG_SOURCE: csr_prdata = {26'd0, cfg_ff.source_node};
         mfba_pkg::REG_SINK:   csr_prdata = {26'd0, cfg_ff.sink_node};
         mfba_pkg::REG_COUNT:  csr_prdata = {25'd0, cfg_ff.node_count};
         default:              csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_node <= 6'd0;
         cfg_ff.sink_node   <= 6'd1;
         cfg_ff.node_count  <= 7'd64;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/mfba_matrix.sv =====
module mfba_matrix #(
   parameter int DEPTH = 4096
) (
   input  logic                         clock,
   input  logic [$clog2(DEPTH)-1:0]     raddr,
   input  logic                         cap_we,
   input  logic [$clog2(DEPTH)-1:0]     cap_waddr,
   input  logic [mfba_pkg::CAP_W-1:0]   cap_wdata,
   input  logic                         flow_we,
   input  logic [$clog2(DEPTH)-1:0]     flow_waddr,
   input  logic [mfba_pkg::FLOW_W-1:0]  flow_wdata,
   output logic [mfba_pkg::CAP_W-1:0]   cap_rdata,
   output logic [mfba_pkg::FLOW_W-1:0]  flow_rdata
);

   logic [mfba_pkg::CAP_W-1:0]  cap_mem  [DEPTH];
   logic [mfba_pkg::FLOW_W-1:0] flow_mem [DEPTH];
   logic [mfba_pkg::CAP_W-1:0]  cap_rd_ff;
   logic [mfba_pkg::FLOW_W-1:0] flow_rd_ff;

   assign cap_rdata  = cap_rd_ff;
   assign flow_rdata = flow_rd_ff;

   // capacity and signed flow side by side, one read address for both
   always_ff @(posedge clock) begin
      if (cap_we) begin
         cap_mem[cap_waddr] <= cap_wdata;
      end
      cap_rd_ff <= cap_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (flow_we) begin
         flow_mem[flow_waddr] <= flow_wdata;
      end
      flow_rd_ff <= flow_mem[raddr];
   end

endmodule

// ===== rtl/max_flow_bfs_augment_unit.sv =====
// Channel  Handshake              Payload
// req      req_valid/req_ready    req_opcode, req_from_node, req_to_node, req_capacity
// rsp      rsp_valid/rsp_ready    rsp_max_flow
// csr      APB-style write/read   source_node, sink_node, node_count
//
// Add edge: read, saturate, write back on the capacity memory.
// Clear graph: all MAX_NODES^2 capacity entries, one capacity entry a cycle.
// Compute: flow clearing over all MAX_NODES^2 entries, then per search a scan of
//    one matrix row per dequeued node, where the single read port sets the pace,
//    plus an update of the flow pair per path hop.
// After reset the capacity memory is swept to zero with req_ready low;
//    configuration writes are taken throughout.
// A finished result sits in an output register; the block takes further
//    items while it waits, and a second compute holds until it drains.
module max_flow_bfs_augment_unit #(
   parameter int MAX_NODES = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_opcode,
   input  logic [5:0]                  req_from_node,
   input  logic [5:0]                  req_to_node,
   input  logic [29:0]                 req_capacity,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [37:0]                 rsp_max_flow,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [3:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   `include "assert_macros.svh"

   localparam int NW    = $clog2(MAX_NODES);
   localparam int DEPTH = MAX_NODES * MAX_NODES;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = mfba_pkg::CAP_W;
   localparam int FW    = mfba_pkg::FLOW_W;
   localparam int TW    = mfba_pkg::TOT_W;

   localparam logic [3:0] S_INIT  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_ADD   = 4'd2;
   localparam logic [3:0] S_FCLR  = 4'd3;
   localparam logic [3:0] S_BINIT = 4'd4;
   localparam logic [3:0] S_DEQ   = 4'd5;
   localparam logic [3:0] S_DEQ2  = 4'd6;
   localparam logic [3:0] S_DEQ3  = 4'd7;
   localparam logic [3:0] S_SCAN  = 4'd8;
   localparam logic [3:0] S_END   = 4'd9;
   localparam logic [3:0] S_AUG0  = 4'd10;
   localparam logic [3:0] S_AUGP  = 4'd11;
   localparam logic [3:0] S_AUGR  = 4'd12;
   localparam logic [3:0] S_AUGW1 = 4'd13;
   localparam logic [3:0] S_AUGW2 = 4'd14;
   localparam logic [3:0] S_DONE  = 4'd15;

   function automatic logic [AW-1:0] mat_addr(input logic [NW-1:0] row,
                                              input logic [NW-1:0] col);
      return AW'(32'(row) * MAX_NODES + 32'(col));
   endfunction

   mfba_pkg::csr_type cfg;

   logic [3:0]            state_ff, state_in;
   logic [AW-1:0]         sweep_ff, sweep_in;
   logic [NW:0]           head_ff, head_in;
   logic [NW:0]           tail_ff, tail_in;
   logic [NW-1:0]         u_ff, u_in;
   logic [CW-1:0]         bu_ff, bu_in;
   logic [NW:0]           v_ff, v_in;
   logic                  pend_ff, pend_in;
   logic [NW-1:0]         pv_ff, pv_in;
   logic [MAX_NODES-1:0]  visited_ff, visited_in;
   logic [CW-1:0]         b_ff, b_in;
   logic [NW-1:0]         av_ff, av_in;
   logic [NW-1:0]         ap_ff, ap_in;
   logic [TW-1:0]         total_ff, total_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0]         rsp_flow_ff, rsp_flow_in;
   logic [AW-1:0]         add_addr_ff, add_addr_in;
   logic [CW-1:0]         add_cap_ff, add_cap_in;

   logic [CW-1:0]         bn_mem    [MAX_NODES];
   logic [NW-1:0]         pred_mem  [MAX_NODES];
   logic [NW-1:0]         queue_mem [MAX_NODES];
   logic [CW-1:0]         bn_rd_ff;
   logic [NW-1:0]         pred_rd_ff;
   logic [NW-1:0]         queue_rd_ff;

   logic                  bn_we, pred_we, queue_we;
   logic [NW-1:0]         bn_waddr, queue_waddr;
   logic [CW-1:0]         bn_wdata;
   logic [NW-1:0]         bn_raddr, pred_raddr, queue_raddr;

   logic [AW-1:0]         mat_raddr;
   logic                  cap_we, flow_we;
   logic [AW-1:0]         cap_waddr, flow_waddr;
   logic [CW-1:0]         cap_wdata;
   logic [FW-1:0]         flow_wdata;
   logic [CW-1:0]         cap_rd;
   logic [FW-1:0]         flow_rd;

   logic [NW:0]           n_eff;
   logic [NW-1:0]         src_idx, snk_idx;
   logic                  degenerate;
   logic                  accept;
   logic signed [FW:0]    resid;
   logic                  resid_pos;
   logic [CW-1:0]         path_min;
   logic [CW:0]           add_sum;

   mfba_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mfba_matrix #(.DEPTH(DEPTH)) u_matrix (
      .clock      (clock),
      .raddr      (mat_raddr),
      .cap_we     (cap_we),
      .cap_waddr  (cap_waddr),
      .cap_wdata  (cap_wdata),
      .flow_we    (flow_we),
      .flow_waddr (flow_waddr),
      .flow_wdata (flow_wdata),
      .cap_rdata  (cap_rd),
      .flow_rdata (flow_rd)
   );

   // clamp node count to the array size
   assign n_eff = (32'(cfg.node_count) > MAX_NODES) ? (NW+1)'(MAX_NODES)
                                                    : (NW+1)'(cfg.node_count);
   assign src_idx    = NW'(32'(cfg.source_node));
   assign snk_idx    = NW'(32'(cfg.sink_node));
   assign degenerate = (32'(cfg.source_node) >= 32'(n_eff)) ||
                       (32'(cfg.sink_node) >= 32'(n_eff)) ||
                       (cfg.source_node == cfg.sink_node);

   assign req_ready    = (state_ff == S_IDLE);
   assign accept       = req_valid & req_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_max_flow = rsp_flow_ff;

   // residual of the entry read last cycle; positive means a usable edge
   assign resid     = $signed({3'b000, cap_rd}) - $signed({flow_rd[FW-1], flow_rd});
   assign resid_pos = !resid[FW] && (resid != '0);
   assign path_min  = ($unsigned(resid) < (FW+1)'(bu_ff)) ? CW'(resid) : bu_ff;
   assign add_sum   = {1'b0, cap_rd} + {1'b0, add_cap_ff};

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      u_in         = u_ff;
      bu_in        = bu_ff;
      v_in         = v_ff;
      pend_in      = 1'b0;
      pv_in        = pv_ff;
      visited_in   = visited_ff;
      b_in         = b_ff;
      av_in        = av_ff;
      ap_in        = ap_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_flow_in  = rsp_flow_ff;
      add_addr_in  = add_addr_ff;
      add_cap_in   = add_cap_ff;
      bn_we        = 1'b0;
      pred_we      = 1'b0;
      queue_we     = 1'b0;
      bn_waddr     = pv_ff;
      bn_wdata     = path_min;
      queue_waddr  = tail_ff[NW-1:0];
      bn_raddr     = u_ff;
      pred_raddr   = av_ff;
      queue_raddr  = head_ff[NW-1:0];
      mat_raddr    = mat_addr(u_ff, v_ff[NW-1:0]);
      cap_we       = 1'b0;
      cap_waddr    = sweep_ff;
      cap_wdata    = '0;
      flow_we      = 1'b0;
      flow_waddr   = sweep_ff;
      flow_wdata   = '0;

      // scan results land in the cycle after the read was issued
      if (pend_ff && resid_pos) begin
         visited_in[pv_ff] = 1'b1;
         bn_we   = 1'b1;
         pred_we = 1'b1;
         if (32'(tail_ff) < MAX_NODES) begin
            queue_we = 1'b1;
            tail_in  = tail_ff + 1'b1;
         end
      end

      case (state_ff)
         S_INIT: begin
            // sweep the capacity memory to zero
            cap_we   = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  mfba_pkg::OP_ADD: begin
                     if (32'(req_from_node) < MAX_NODES && 32'(req_to_node) < MAX_NODES) begin
                        add_addr_in = mat_addr(NW'(32'(req_from_node)),
                                               NW'(32'(req_to_node)));
                        mat_raddr   = add_addr_in;
                        add_cap_in  = req_capacity;
                        state_in    = S_ADD;
                     end
                  end
                  mfba_pkg::OP_COMPUTE: begin
                     sweep_in = '0;
                     state_in = S_FCLR;
                  end
                  mfba_pkg::OP_CLEAR: begin
                     sweep_in = '0;
                     state_in = S_INIT;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_ADD: begin
            // saturate the accumulated capacity
            cap_we    = 1'b1;
            cap_waddr = add_addr_ff;
            cap_wdata = (add_sum > (CW+1)'(mfba_pkg::CAP_LIMIT)) ? mfba_pkg::CAP_LIMIT
                                                                : add_sum[CW-1:0];
            state_in  = S_IDLE;
         end
         S_FCLR: begin
            flow_we  = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == AW'(DEPTH - 1)) begin
               total_in = '0;
               state_in = degenerate ? S_DONE : S_BINIT;
            end
         end
         S_BINIT: begin
            // seed a new search at the source
            visited_in          = '0;
            visited_in[src_idx] = 1'b1;
            bn_we       = 1'b1;
            bn_waddr    = src_idx;
            bn_wdata    = mfba_pkg::START_BOTTLE;
            queue_we    = 1'b1;
            queue_waddr = '0;
            head_in     = '0;
            tail_in     = (NW+1)'(1);
            state_in    = S_DEQ;
         end
         S_DEQ: begin
            if (head_ff == tail_ff) begin
               state_in = S_END;
            end else begin
               head_in  = head_ff + 1'b1;
               state_in = S_DEQ2;
            end
         end
         S_DEQ2: begin
            u_in     = queue_rd_ff;
            bn_raddr = queue_rd_ff;
            state_in = S_DEQ3;
         end
         S_DEQ3: begin
            bu_in    = bn_rd_ff;
            v_in     = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (v_ff < n_eff) begin
               pend_in = ~visited_ff[v_ff[NW-1:0]];
               pv_in   = v_ff[NW-1:0];
               v_in    = v_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in = S_DEQ;
            end
         end
         S_END: begin
            bn_raddr = snk_idx;
            state_in = visited_ff[snk_idx] ? S_AUG0 : S_DONE;
         end
         S_AUG0: begin
            b_in     = bn_rd_ff;
            total_in = total_ff + TW'(bn_rd_ff);
            av_in    = snk_idx;
            state_in = S_AUGP;
         end
         S_AUGP: begin
            // walk the path back from the sink
            state_in = (av_ff == src_idx) ? S_BINIT : S_AUGR;
         end
         S_AUGR: begin
            ap_in     = pred_rd_ff;
            mat_raddr = mat_addr(pred_rd_ff, av_ff);
            state_in  = S_AUGW1;
         end
         S_AUGW1: begin
            flow_we    = 1'b1;
            flow_waddr = mat_addr(ap_ff, av_ff);
            flow_wdata = flow_rd + FW'(b_ff);
            mat_raddr  = mat_addr(av_ff, ap_ff);
            state_in   = S_AUGW2;
         end
         S_AUGW2: begin
            flow_we    = 1'b1;
            flow_waddr = mat_addr(av_ff, ap_ff);
            flow_wdata = flow_rd - FW'(b_ff);
            av_in      = ap_ff;
            state_in   = S_AUGP;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_flow_in  = total_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (bn_we) begin
         bn_mem[bn_waddr] <= bn_wdata;
      end
      if (pred_we) begin
         pred_mem[pv_ff] <= u_ff;
      end
      if (queue_we) begin
         queue_mem[queue_waddr] <= (state_ff == S_BINIT) ? src_idx : pv_ff;
      end
      bn_rd_ff    <= bn_mem[bn_raddr];
      pred_rd_ff  <= pred_mem[pred_raddr];
      queue_rd_ff <= queue_mem[queue_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         sweep_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         pend_ff      <= 1'b0;
         visited_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         pend_ff      <= pend_in;
         visited_ff   <= visited_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff        <= u_in;
      bu_ff       <= bu_in;
      v_ff        <= v_in;
      pv_ff       <= pv_in;
      b_ff        <= b_in;
      av_ff       <= av_in;
      ap_ff       <= ap_in;
      total_ff    <= total_in;
      rsp_flow_ff <= rsp_flow_in;
      add_addr_ff <= add_addr_in;
      add_cap_ff  <= add_cap_in;
   end

   `MFBA_ALWAYS(a_head_le_tail, head_ff <= tail_ff, "queue head passed tail")
   `MFBA_ALWAYS(a_tail_bound, 32'(tail_ff) <= MAX_NODES, "queue tail out of range")
   `MFBA_IMPLY(a_src_visited, state_ff == S_SCAN, visited_ff[src_idx], "source not marked")
   `MFBA_IMPLY(a_cap_sat, cap_we, cap_wdata <= mfba_pkg::CAP_LIMIT, "capacity above limit")
   `MFBA_IMPLY(a_pend_scan, pend_ff, $past(state_ff) == S_SCAN, "scan read outside scan")

endmodule

// ===== tb/sv/max_flow_bfs_augment_unit_tb.sv =====
module max_flow_bfs_augment_unit_tb;

   // Opcode 3 has no meaning in the block; it must be swallowed silently.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int NODES = 64;
   // Worst single wait: a clearing pass over the capacity memory.
   localparam int SETTLE_CYCLES = 4400;
   localparam int CYCLE_LIMIT = 3000000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_opcode;
   logic [5:0]  req_from_node;
   logic [5:0]  req_to_node;
   logic [29:0] req_capacity;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [37:0] rsp_max_flow;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predictor of the block: capacity graph, registers and the queue of
   // max-flow totals still owed by the block.
   class flow_scoreboard;
      bit [29:0]         cap_mx[NODES*NODES];
      bit [5:0]          src;
      bit [5:0]          snk;
      bit [6:0]          cnt;
      bit [37:0]         owed_totals[$];
      int                failures;
      int                results_seen;

      function void set_reg(logic [1:0] idx, logic [31:0] value);
         if (idx == mfba_pkg::REG_SOURCE) src = value[5:0];
         else if (idx == mfba_pkg::REG_SINK) snk = value[5:0];
         else if (idx == mfba_pkg::REG_COUNT) cnt = value[6:0];
      endfunction

      function int pending();
         return owed_totals.size();
      endfunction

      // Run the augmenting-path search to completion and return the total.
      function bit [37:0] solve_max_flow();
         int flow_mx[NODES*NODES];
         int unsigned bott[NODES];
         int pred[NODES];
         int q[NODES];
         int n, head, tail, u, v, p;
         longint r;
         longint unsigned total;
         int unsigned b;
         n = (cnt > NODES) ? NODES : cnt;
         total = 0;
         foreach (flow_mx[i]) flow_mx[i] = 0;
         if (src >= n || snk >= n || src == snk) return '0;
         while (1) begin
            foreach (bott[i]) bott[i] = 0;
            bott[src] = mfba_pkg::START_BOTTLE;
            q[0] = src;
            head = 0;
            tail = 1;
            while (head < tail) begin
               u = q[head];
               head++;
               for (v = 0; v < n; v++) begin
                  if (bott[v] != 0) continue;
                  r = longint'(cap_mx[u*NODES+v]) - longint'(flow_mx[u*NODES+v]);
                  if (r <= 0) continue;
                  bott[v] = (r < longint'(bott[u])) ? int'(r) : bott[u];
                  pred[v] = u;
                  if (tail < NODES) begin
                     q[tail] = v;
                     tail++;
                  end
               end
            end
            if (bott[snk] == 0) break;
            // Push the bottleneck along the path, keeping flows antisymmetric.
            b = bott[snk];
            v = snk;
            while (v != src) begin
               p = pred[v];
               flow_mx[p*NODES+v] += b;
               flow_mx[v*NODES+p] -= b;
               v = p;
            end
            total += b;
         end
         return total[37:0];
      endfunction

      function void note_request(logic [1:0] op, logic [5:0] f, logic [5:0] t,
                                 logic [29:0] c);
         bit [32:0] sum;
         if (op == mfba_pkg::OP_ADD) begin
            sum = cap_mx[f*NODES+t] + c;
            cap_mx[f*NODES+t] = (sum > mfba_pkg::CAP_LIMIT) ? mfba_pkg::CAP_LIMIT
                                                            : sum[29:0];
         end else if (op == mfba_pkg::OP_COMPUTE) begin
            owed_totals.push_back(solve_max_flow());
         end else if (op == mfba_pkg::OP_CLEAR) begin
            foreach (cap_mx[i]) cap_mx[i] = '0;
         end
      endfunction

      function void check_result(logic [37:0] got);
         bit [37:0] want;
         results_seen++;
         if (owed_totals.size() == 0) begin
            $error("max_flow beat with nothing expected: actual %0d", got);
            failures++;
            return;
         end
         want = owed_totals.pop_front();
         if (got !== want) begin
            $error("max_flow mismatch: expected %0d, actual %0d", want, got);
            failures++;
         end
      endfunction
   endclass

   flow_scoreboard flow_sb;
   int  cycle_count;
   int  items_sent;
   int  phases_run;
   bit  quiet;
   int  stall_left;

   max_flow_bfs_augment_unit i_dut (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Sample both handshakes at the rising edge, before the block updates.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            flow_sb.note_request(req_opcode, req_from_node, req_to_node, req_capacity);
         if (rsp_valid && rsp_ready)
            flow_sb.check_result(rsp_max_flow);
      end
   end

   // Stall the result side in random bursts; hold ready high when quiet.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) < 3) begin
         stall_left = $urandom_range(1, 6) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Bail out if the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("max_flow_bfs_augment_unit test failed");
         $finish;
      end
   end

   // Drive one request beat; valid stays high into the next beat.
   task automatic send_req(logic [1:0] op, logic [5:0] f, logic [5:0] t,
                           logic [29:0] c);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_from_node <= f;
      req_to_node   <= t;
      req_capacity  <= c;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic add_edge(int f, int t, logic [29:0] c);
      send_req(mfba_pkg::OP_ADD, f[5:0], t[5:0], c);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      req_valid   <= 1'b0;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      flow_sb.set_reg(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Wait out owed results plus any clearing pass still in flight.
   task automatic settle();
      req_valid <= 1'b0;
      while (flow_sb.pending() > 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(int s, int k, int n);
      settle();
      write_reg(mfba_pkg::REG_SOURCE, s);
      write_reg(mfba_pkg::REG_SINK, k);
      write_reg(mfba_pkg::REG_COUNT, n);
      phases_run++;
   endtask

   function automatic logic [29:0] pick_capacity();
      int sel;
      sel = $urandom_range(0, 5);
      if (sel < 2) return 30'($urandom_range(1, 20));
      if (sel < 4) return 30'($urandom_range(0, 1000));
      if (sel == 4) return 30'($urandom());
      return {$urandom_range(0, 1) ? 30'h3fffffff : mfba_pkg::CAP_LIMIT};
   endfunction

   // One phase of random traffic, mostly edges among the active nodes.
   task automatic random_phase(int n, int beats);
      int sel, top;
      top = (n < 1) ? 1 : ((n > NODES) ? NODES : n);
      for (int i = 0; i < beats; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 6)
            send_req(OP_UNUSED, 6'($urandom()), 6'($urandom()), 30'($urandom()));
         else if (sel < 12)
            add_edge($urandom_range(0, 63), $urandom_range(0, 63), pick_capacity());
         else if (sel < 16)
            send_req(mfba_pkg::OP_CLEAR, 6'($urandom()), 6'($urandom()),
                     30'($urandom()));
         else if (sel < 32)
            send_req(mfba_pkg::OP_COMPUTE, 6'($urandom()), 6'($urandom()),
                     30'($urandom()));
         else
            add_edge($urandom_range(0, top-1), $urandom_range(0, top-1), pick_capacity());
      end
      send_req(mfba_pkg::OP_COMPUTE, '0, '0, '0);
   endtask

   initial begin
      flow_sb = new();
      flow_sb.src = 6'd0;
      flow_sb.snk = 6'd1;
      flow_sb.cnt = 7'd64;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_opcode    = mfba_pkg::OP_ADD;
      req_from_node = '0;
      req_to_node   = '0;
      req_capacity  = '0;
      rsp_ready     = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      quiet         = 1'b0;
      stall_left    = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: zero capacity, saturation, self loops, reverse residuals.
      add_edge(0, 1, 30'd0);
      send_req(mfba_pkg::OP_COMPUTE, '0, '0, '0);
      add_edge(0, 1, 30'h3fffffff);
      add_edge(0, 1, 30'd5);
      add_edge(1, 1, 30'd100);
      add_edge(63, 63, mfba_pkg::CAP_LIMIT);
      send_req(mfba_pkg::OP_COMPUTE, 6'h3f, 6'h3f, 30'h3fffffff);
      send_req(mfba_pkg::OP_CLEAR, '0, '0, '0);
      // Cross graph where a first path through 2 and 3 would have to be undone.
      add_edge(0, 2, 30'd1);
      add_edge(0, 3, 30'd1);
      add_edge(2, 3, 30'd1);
      add_edge(2, 1, 30'd1);
      add_edge(3, 1, 30'd1);
      add_edge(0, 63, 30'd7);
      add_edge(63, 1, 30'd3);
      send_req(OP_UNUSED, 6'h3f, 6'h3f, 30'h3fffffff);
      send_req(mfba_pkg::OP_COMPUTE, '0, '0, '0);
      send_req(mfba_pkg::OP_CLEAR, '0, '0, '0);
      send_req(mfba_pkg::OP_COMPUTE, '0, '0, '0);

      // Register extremes: zero nodes, oversize count, equal ends, one node.
      configure(0, 1, 0);
      add_edge(0, 1, 30'd9);
      send_req(mfba_pkg::OP_COMPUTE, '0, '0, '0);
      configure(63, 0, 127);
      add_edge(63, 0, 30'd11);
      add_edge(63, 5, 30'd4);
      add_edge(5, 0, 30'd6);
      send_req(mfba_pkg::OP_COMPUTE, '0, '0, '0);
      configure(5, 5, 8);
      send_req(mfba_pkg::OP_COMPUTE, '0, '0, '0);
      configure(0, 0, 1);
      send_req(mfba_pkg::OP_COMPUTE, '0, '0, '0);

      // Random phases over small graphs, with one full-size graph.
      configure(0, 63, 64);
      random_phase(64, 14);
      for (int ph = 0; ph < 6; ph++) begin
         int n, s, k;
         n = $urandom_range(2, 10);
         s = $urandom_range(0, n-1);
         k = $urandom_range(0, n-1);
         if (k == s) k = (s + 1) % n;
         if (ph == 5) quiet = 1'b1;
         configure(s, k, n);
         if ($urandom_range(0, 1)) send_req(mfba_pkg::OP_CLEAR, '0, '0, '0);
         random_phase(n, 15);
      end

      settle();
      $display("Covered %0d request beats and %0d max-flow results over %0d register phases.",
               items_sent, flow_sb.results_seen, phases_run);
      if (flow_sb.failures == 0 && flow_sb.pending() == 0) begin
         $display("max_flow_bfs_augment_unit test passed");
      end else begin
         $display("max_flow_bfs_augment_unit test failed");
      end
      $finish;
   end

endmodule
